// File: sv/etkk_pkg.sv
// ----------------------------------------------------------------------------
// etkk_pkg
// Shared types and constants for the top-K keeper.
// ----------------------------------------------------------------------------
package etkk_pkg;

  localparam int CAPACITY   = 16;
  localparam int SCORE_BITS = 32;
  localparam int TAG_BITS   = 16;

  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W     = $clog2(CAPACITY + 1);
  localparam int ENTRY_W    = SCORE_BITS + TAG_BITS;

  localparam int KIND_W     = 2;
  localparam int RANK_W     = 6;
  localparam int OFILL_W    = 7;
  localparam int KEEP_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_THRESHOLD = 2'd1;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd16;

  localparam logic signed [SCORE_BITS-1:0] SCORE_MOST_NEG =
    {1'b1, {(SCORE_BITS-1){1'b0}}};

  typedef struct packed {
    logic                         mode;
    logic signed [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]          tag;
  } in_t;

  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic                         accepted;
    logic [TAG_BITS-1:0]          entry_tag;
    logic signed [SCORE_BITS-1:0] entry_score;
    logic [RANK_W-1:0]            rank;
    logic [OFILL_W-1:0]           fill;
    logic                         new_best;
    logic                         last;
  } out_t;

  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score;
    logic [TAG_BITS-1:0]          tag;
  } entry_t;

  // effective keep limit (1..CAPACITY) and threshold enable
  typedef struct packed {
    logic [FILL_W-1:0] keep_lim;
    logic              use_thr;
  } cfg_t;

endpackage

// File: sv/elite_top_k_keeper.sv
// ----------------------------------------------------------------------------
// elite_top_k_keeper
// Keeps the best-scoring samples of a round, sorted, in a small entry RAM.
// ----------------------------------------------------------------------------
// Usage: offers (mode 0) and closes (mode 1) arrive on the in_ channel; each
// offer yields one answer, a close yields one transaction per kept entry in
// rank order (last on the final one) or a single empty-round transaction.
// Registers keep_count and use_threshold are written on the cfg_ channel,
// which is always ready; write them only while no transaction is in flight.
// Offer: the entry RAM is walked from the worst kept entry toward the
// insert point, one entry per cycle through its single read and write
// port, then the new entry is written and the answer loaded. A rejected
// offer stops at the worst entry. The answer then waits for a free output
// register, and the input is ready again once the answer has moved into
// the output register.
// Close: kept entries are read from rank 0 and passed to the output one
// per cycle while the output register is free; an empty close answers as an offer does.
// The output register lets the next transaction be accepted while the
// previous answer is still waiting.
// Reset: empty list, threshold and best-ever score at the most negative
// value, keep_count 16, threshold off. A stalled receiver freezes the
// output register, pauses close streaming and, once the next answer is
// ready, holds in_ready low.
// ----------------------------------------------------------------------------
module elite_top_k_keeper (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  etkk_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output etkk_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [etkk_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [etkk_pkg::CFG_DATA_W-1:0] cfg_data
);
  import etkk_pkg::*;

  cfg_t               cfg;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  etkk_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  etkk_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  etkk_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// File: sv/etkk_ram.sv
// ----------------------------------------------------------------------------
// etkk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module etkk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/etkk_cfg.sv
// ----------------------------------------------------------------------------
// etkk_cfg
// Configuration registers and effective keep-limit clamp.
// ----------------------------------------------------------------------------
module etkk_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [etkk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etkk_pkg::CFG_DATA_W-1:0]  cfg_data,
  output etkk_pkg::cfg_t                   cfg
);
  import etkk_pkg::*;

  logic [KEEP_W-1:0] keep_count_r, keep_count_nxt;
  logic              use_thr_r, use_thr_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    keep_count_nxt = keep_count_r;
    use_thr_nxt    = use_thr_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_KEEP_COUNT:    keep_count_nxt = cfg_data[KEEP_W-1:0];
        CFG_USE_THRESHOLD: use_thr_nxt    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r <= KEEP_RESET;
      use_thr_r    <= 1'b0;
    end else begin
      keep_count_r <= keep_count_nxt;
      use_thr_r    <= use_thr_nxt;
    end
  end

  // zero counts as one, anything above capacity saturates
  always_comb begin
    if (keep_count_r == '0) begin
      cfg.keep_lim = FILL_W'(1);
    end else if (keep_count_r > KEEP_W'(CAPACITY)) begin
      cfg.keep_lim = FILL_W'(CAPACITY);
    end else begin
      cfg.keep_lim = keep_count_r[FILL_W-1:0];
    end
    cfg.use_thr = use_thr_r;
  end

endmodule

// File: sv/etkk_seq.sv
// ----------------------------------------------------------------------------
// etkk_seq
// Sequencer: insertion walk over the entry RAM, close streaming, output reg.
// ----------------------------------------------------------------------------
module etkk_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  etkk_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  etkk_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output etkk_pkg::out_t                out_data,
  output logic                          mem_we,
  output logic [etkk_pkg::ADDR_W-1:0]   mem_waddr,
  output logic [etkk_pkg::ENTRY_W-1:0]  mem_wdata,
  output logic                          mem_re,
  output logic [etkk_pkg::ADDR_W-1:0]   mem_raddr,
  input  logic [etkk_pkg::ENTRY_W-1:0]  mem_rdata
);
  import etkk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,
    S_INS   = 5'b00100,
    S_RESP  = 5'b01000,
    S_CLOSE = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [FILL_W-1:0]            fill_r, fill_nxt;
  logic signed [SCORE_BITS-1:0] thr_r, thr_nxt;
  logic signed [SCORE_BITS-1:0] best_sc_r, best_sc_nxt;
  logic [TAG_BITS-1:0]          best_tg_r, best_tg_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic signed [SCORE_BITS-1:0] sc_r, sc_nxt;
  logic [TAG_BITS-1:0]          tg_r, tg_nxt;
  logic                         thr_ok_r, thr_ok_nxt;
  logic                         full_r, full_nxt;
  logic [FILL_W-1:0]            ffill_r, ffill_nxt;
  logic [ADDR_W-1:0]            cur_r, cur_nxt;
  logic                         first_r, first_nxt;
  logic [ADDR_W-1:0]            pos_r, pos_nxt;
  logic signed [SCORE_BITS-1:0] worst_r, worst_nxt;
  logic                         nb_r, nb_nxt;
  out_t                         resp_r, resp_nxt;
  out_t                         out_r, out_nxt;

  entry_t                       rd_e;
  entry_t                       wr_e;
  logic [FILL_W-1:0]            fill_t;
  logic [FILL_W-1:0]            cur_w;
  logic                         out_free;
  logic                         nb_cur;
  logic                         is_last;

  assign rd_e     = entry_t'(mem_rdata);
  assign mem_wdata = wr_e;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign fill_t   = (fill_r > cfg.keep_lim) ? cfg.keep_lim : fill_r;
  assign cur_w    = FILL_W'(cur_r);
  assign nb_cur   = (cur_r == '0) ? (rd_e.score > best_sc_r) : nb_r;
  assign is_last  = ((cur_w + FILL_W'(1)) == fill_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    thr_nxt       = thr_r;
    best_sc_nxt   = best_sc_r;
    best_tg_nxt   = best_tg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    sc_nxt        = sc_r;
    tg_nxt        = tg_r;
    thr_ok_nxt    = thr_ok_r;
    full_nxt      = full_r;
    ffill_nxt     = ffill_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    pos_nxt       = pos_r;
    worst_nxt     = worst_r;
    nb_nxt        = nb_r;
    resp_nxt      = resp_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = cur_r;
    wr_e          = rd_e;
    mem_re        = 1'b0;
    mem_raddr     = cur_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          resp_nxt      = '0;
          resp_nxt.kind = KIND_OFFER;
          resp_nxt.last = 1'b1;
          if (!in_data.mode) begin
            sc_nxt     = in_data.score;
            tg_nxt     = in_data.tag;
            thr_ok_nxt = !cfg.use_thr || (in_data.score > thr_r);
            full_nxt   = (fill_t >= cfg.keep_lim);
            ffill_nxt  = (fill_t >= cfg.keep_lim) ? fill_t : fill_t + FILL_W'(1);
            fill_nxt   = fill_t;
            if (fill_t == '0) begin
              pos_nxt = '0;
              if (!cfg.use_thr || (in_data.score > thr_r)) begin
                state_nxt = S_INS;
              end else begin
                state_nxt = S_RESP;
              end
            end else begin
              // start the walk at the current worst entry
              mem_re    = 1'b1;
              mem_raddr = ADDR_W'(fill_t - FILL_W'(1));
              cur_nxt   = ADDR_W'(fill_t - FILL_W'(1));
              first_nxt = 1'b1;
              state_nxt = S_WALK;
            end
          end else begin
            if (fill_r == '0) begin
              resp_nxt.kind = KIND_EMPTY;
              state_nxt     = S_RESP;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              cur_nxt   = '0;
              state_nxt = S_CLOSE;
            end
          end
        end
      end

      S_WALK: begin
        if (first_r && !(thr_ok_r && (!full_r || (sc_r > rd_e.score)))) begin
          resp_nxt.entry_score = rd_e.score;
          resp_nxt.fill        = OFILL_W'(fill_r);
          state_nxt            = S_RESP;
        end else begin
          first_nxt = 1'b0;
          if (rd_e.score > sc_r) begin
            pos_nxt   = cur_r + ADDR_W'(1);
            state_nxt = S_INS;
          end else begin
            // shift down one slot; the worst of a full list falls off
            if (!(first_r && full_r)) begin
              mem_we    = 1'b1;
              mem_waddr = cur_r + ADDR_W'(1);
              wr_e      = rd_e;
              if ((cur_w + FILL_W'(1)) == (ffill_r - FILL_W'(1))) begin
                worst_nxt = rd_e.score;
              end
            end
            if (cur_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_INS;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = cur_r - ADDR_W'(1);
              cur_nxt   = cur_r - ADDR_W'(1);
            end
          end
        end
      end

      S_INS: begin
        mem_we      = 1'b1;
        mem_waddr   = pos_r;
        wr_e.score  = sc_r;
        wr_e.tag    = tg_r;
        fill_nxt    = ffill_r;
        resp_nxt.accepted    = 1'b1;
        resp_nxt.rank        = RANK_W'(pos_r);
        resp_nxt.fill        = OFILL_W'(ffill_r);
        resp_nxt.entry_score = (FILL_W'(pos_r) == (ffill_r - FILL_W'(1))) ? sc_r : worst_r;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_nxt       = resp_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_CLOSE: begin
        // read data holds while the output register is stalled
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt              = '0;
          out_nxt.kind         = KIND_ENTRY;
          out_nxt.entry_tag    = rd_e.tag;
          out_nxt.entry_score  = rd_e.score;
          out_nxt.rank         = RANK_W'(cur_r);
          out_nxt.fill         = OFILL_W'(fill_r);
          out_nxt.new_best     = nb_cur;
          out_nxt.last         = is_last;
          nb_nxt               = nb_cur;
          if ((cur_r == '0) && nb_cur) begin
            best_sc_nxt = rd_e.score;
            best_tg_nxt = rd_e.tag;
          end
          if (is_last) begin
            if (cfg.use_thr) begin
              thr_nxt = rd_e.score;
            end
            fill_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = cur_r + ADDR_W'(1);
            cur_nxt   = cur_r + ADDR_W'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      thr_r       <= SCORE_MOST_NEG;
      best_sc_r   <= SCORE_MOST_NEG;
      best_tg_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      thr_r       <= thr_nxt;
      best_sc_r   <= best_sc_nxt;
      best_tg_r   <= best_tg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sc_r     <= sc_nxt;
    tg_r     <= tg_nxt;
    thr_ok_r <= thr_ok_nxt;
    full_r   <= full_nxt;
    ffill_r  <= ffill_nxt;
    cur_r    <= cur_nxt;
    first_r  <= first_nxt;
    pos_r    <= pos_nxt;
    worst_r  <= worst_nxt;
    nb_r     <= nb_nxt;
    resp_r   <= resp_nxt;
    out_r    <= out_nxt;
  end

endmodule

// File: bench/tb_elite_top_k_keeper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elite_top_k_keeper
// Self-checking bench for the top-K keeper: a scoreboard class tracks the
// sorted list, threshold and best-ever score, predicts every offer answer
// and close listing, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_elite_top_k_keeper;
  import etkk_pkg::*;

  localparam logic MODE_OFFER = 1'b0;
  localparam logic MODE_CLOSE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = ~SCORE_MOST_NEG;
  localparam int ITEMS_TOTAL  = 460;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_PRINTS   = 100;

  class topk_scoreboard;
    out_t                         expected_q[$];
    logic signed [SCORE_BITS-1:0] kept_score[CAPACITY];
    logic [TAG_BITS-1:0]          kept_tag[CAPACITY];
    int unsigned                  kept_n;
    logic signed [SCORE_BITS-1:0] floor_score;
    logic signed [SCORE_BITS-1:0] best_score;
    logic [TAG_BITS-1:0]          best_tag;
    logic [KEEP_W-1:0]            keep_reg;
    logic                         use_floor;
    int                           errors;
    int                           n_checked;

    function new();
      kept_n      = 0;
      floor_score = SCORE_MOST_NEG;
      best_score  = SCORE_MOST_NEG;
      best_tag    = '0;
      keep_reg    = KEEP_RESET;
      use_floor   = 1'b0;
      errors      = 0;
      n_checked   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == CFG_KEEP_COUNT) keep_reg = d[KEEP_W-1:0];
      else if (idx == CFG_USE_THRESHOLD) use_floor = d[0];
    endfunction

    function int unsigned keep_limit();
      if (keep_reg == 0) return 1;
      if (keep_reg > CAPACITY) return CAPACITY;
      return keep_reg;
    endfunction

    function void note_item(in_t it);
      int unsigned k;
      int unsigned pos;
      int unsigned i;
      bit          full;
      bit          ok;
      bit          nb;
      out_t        r;
      k = keep_limit();
      if (it.mode == MODE_OFFER) begin
        // a lowered keep count trims the worst entries first
        if (kept_n > k) kept_n = k;
        full = (kept_n >= k);
        ok = !full || (it.score > kept_score[kept_n-1]);
        if (use_floor && !(it.score > floor_score)) ok = 1'b0;
        pos = 0;
        if (ok) begin
          // new entry goes ahead of equal scores
          while (pos < kept_n && kept_score[pos] > it.score) pos++;
          if (full) kept_n--;
          for (i = kept_n; i > pos; i--) begin
            kept_score[i] = kept_score[i-1];
            kept_tag[i]   = kept_tag[i-1];
          end
          kept_score[pos] = it.score;
          kept_tag[pos]   = it.tag;
          kept_n++;
        end
        r = '0;
        r.kind        = KIND_OFFER;
        r.accepted    = ok;
        r.entry_score = (kept_n != 0) ? kept_score[kept_n-1] : '0;
        r.rank        = ok ? RANK_W'(pos) : '0;
        r.fill        = OFILL_W'(kept_n);
        r.last        = 1'b1;
        expected_q = {expected_q, r};
      end else if (kept_n == 0) begin
        r = '0;
        r.kind = KIND_EMPTY;
        r.last = 1'b1;
        expected_q = {expected_q, r};
      end else begin
        nb = (kept_score[0] > best_score);
        for (i = 0; i < kept_n; i++) begin
          r = '0;
          r.kind        = KIND_ENTRY;
          r.entry_tag   = kept_tag[i];
          r.entry_score = kept_score[i];
          r.rank        = RANK_W'(i);
          r.fill        = OFILL_W'(kept_n);
          r.new_best    = nb;
          r.last        = (i + 1 == kept_n);
          expected_q = {expected_q, r};
        end
        if (use_floor) floor_score = kept_score[kept_n-1];
        if (nb) begin
          best_score = kept_score[0];
          best_tag   = kept_tag[0];
        end
        kept_n = 0;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH %0t: %s", $time, msg);
    endtask

    task cmp(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", n_checked, name, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      cmp("kind", got.kind, want.kind);
      cmp("accepted", got.accepted, want.accepted);
      cmp("entry_tag", got.entry_tag, want.entry_tag);
      cmp("entry_score", got.entry_score, want.entry_score);
      cmp("rank", got.rank, want.rank);
      cmp("fill", got.fill, want.fill);
      cmp("new_best", got.new_best, want.new_best);
      cmp("last", got.last, want.last);
      n_checked++;
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  topk_scoreboard sb;
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int cycle_count   = 0;

  elite_top_k_keeper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  task automatic send_item(in_t d);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_offer(logic signed [SCORE_BITS-1:0] score, logic [TAG_BITS-1:0] tag);
    in_t d;
    d.mode  = MODE_OFFER;
    d.score = score;
    d.tag   = tag;
    send_item(d);
  endtask

  task automatic send_close();
    in_t d;
    d.mode  = MODE_CLOSE;
    d.score = $urandom;
    d.tag   = TAG_BITS'($urandom);
    send_item(d);
  endtask

  // stop offering and wait until every expected transaction has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [KEEP_W-1:0] keep, logic thr);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    v[0] = thr;
    cfg_write(CFG_KEEP_COUNT, keep);
    cfg_write(CFG_USE_THRESHOLD, v);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return KEEP_W'(1);
      2: return KEEP_W'(2);
      3: return KEEP_W'(3);
      4: return KEEP_W'(CAPACITY);
      5: return KEEP_W'(CAPACITY + 1);
      6: return KEEP_W'(64);
      7: return {KEEP_W{1'b1}};
      default: return KEEP_W'($urandom_range(1, CAPACITY));
    endcase
  endfunction

  // small range gives plenty of equal scores
  function automatic logic signed [SCORE_BITS-1:0] rand_score();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 15)) - 8;
      8: return SCORE_MAX;
      9: return SCORE_MOST_NEG;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_round();
    int n;
    int i;
    if ($urandom_range(3) == 0) begin
      wait_drained();
      set_config(pick_keep(), $urandom_range(99) < 20);
    end
    n = $urandom_range(0, CAPACITY + 4);
    if ($urandom_range(7) == 0) begin
      // noise: random mix of offers and closes
      for (i = 0; i < n; i++) begin
        if ($urandom_range(1)) send_close();
        else send_offer(rand_score(), TAG_BITS'($urandom));
      end
    end else begin
      for (i = 0; i < n; i++) send_offer(rand_score(), TAG_BITS'($urandom));
      send_close();
    end
  endtask

  task automatic directed_part();
    int i;
    send_close();                              // empty round
    send_offer(SCORE_MAX, '1);
    send_offer(SCORE_MOST_NEG, '0);
    send_offer('0, 16'h1234);
    send_offer('0, 16'h5678);                  // ties with an earlier entry
    send_offer(-1, 16'h0001);
    send_close();
    wait_drained();
    cfg_write(CFG_IDX_SPARE, CFG_DATA_W'($urandom));
    set_config(KEEP_W'(1), 1'b1);
    send_offer(SCORE_MOST_NEG, 16'h00aa);      // blocked by the reset threshold
    send_offer(5, 16'h0005);
    send_offer(3, 16'h0003);                   // full, not better
    send_offer(9, 16'h0009);                   // replaces the worst
    send_close();
    send_offer(9, 16'h0019);                   // equal to threshold
    send_offer(10, 16'h000a);
    send_close();
    wait_drained();
    set_config(KEEP_W'(CAPACITY), 1'b0);
    for (i = 0; i < 4; i++) send_offer(rand_score(), TAG_BITS'($urandom));
    wait_drained();
    set_config(KEEP_W'(2), 1'b0);              // lowered with entries kept
    send_offer(rand_score(), TAG_BITS'($urandom));
    send_close();
    wait_drained();
    set_config('0, 1'b0);
    send_offer(-7, 16'h0107);
    send_offer(7, 16'h0007);
    send_close();
    wait_drained();
  endtask

  initial begin
    int base;
    int phase;
    int i;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    base = items_sent;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 67; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 67; end
        default: begin in_idle_pct = 22; out_stall_pct = 22; end
      endcase
      if (phase == 0) begin
        // long receiver hold-off while offers keep coming, then a full drain
        wait_drained();
        set_config(KEEP_W'(CAPACITY), 1'b0);
        hold_request = HOLD_CYCLES;
        for (i = 0; i < 30; i++) send_offer(rand_score(), TAG_BITS'($urandom));
        send_close();
        wait_drained();
      end
      while (items_sent < base + (ITEMS_TOTAL - base) * (phase + 1) / 4) random_round();
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: elite_top_k_keeper.f
sv/etkk_pkg.sv
sv/etkk_ram.sv
sv/etkk_cfg.sv
sv/etkk_seq.sv
sv/elite_top_k_keeper.sv
bench/tb_elite_top_k_keeper.sv
